// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define AST_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hdl/cdpi_pkg.sv =====
// Package: widths, reset values and register indexes of the clock discipline loop.
`timescale 1ns / 1ps

package cdpi_pkg;

	localparam int TIME_W         = 64;
	localparam int TIME_FRAC_BITS = 32;
	localparam int SEC_W          = 6;
	localparam int EPOCH_W        = 32;
	localparam int LAST_W         = 7;
	localparam int CFG_W          = 32;
	localparam int GAIN_W         = 16;
	localparam int GAIN_FRAC_BITS = 16;
	// Integral is clamped to +/- a 32-bit limit, so 33 signed bits hold it.
	localparam int INTEG_W        = CFG_W + 1;
	localparam int SUM_W          = TIME_W + 2;
	localparam int PROD_W         = INTEG_W + GAIN_W + 1;
	localparam int ADJ_W          = PROD_W - GAIN_FRAC_BITS;

	localparam logic [LAST_W-1:0] NO_SECOND = 7'd127;

	localparam logic [CFG_W-1:0]  STEP_INTERVAL_RST  = 32'd536870912;
	localparam logic [CFG_W-1:0]  STEP_LIMIT_RST     = 32'd536870912;
	localparam logic [CFG_W-1:0]  INTEGRAL_LIMIT_RST = 32'd536870912;
	localparam logic [GAIN_W-1:0] INTEGRAL_GAIN_RST  = 16'd328;

	typedef enum logic [1:0] {
		REG_STEP_INTERVAL  = 2'd0,
		REG_STEP_LIMIT     = 2'd1,
		REG_INTEGRAL_LIMIT = 2'd2,
		REG_INTEGRAL_GAIN  = 2'd3
	} cfg_reg_t;

endpackage

// ===== hdl/clock_discipline_pi.sv =====
// Integral-only clock discipline loop: RTC polls in, disciplined 32.32 timestamp out.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid / in_stall) carries one RTC poll: rtc_second and
//   rtc_epoch_seconds. Output channel (out_valid / out_stall) returns one
//   result per poll: the updated timestamp and the stepped flag.
//   Configuration writes go over cfg_valid / cfg_ready with cfg_index and
//   cfg_data; cfg_ready is always high. Write only while the block is idle.
// Timing:
//   A transferred poll is held in the input register; its result is computed
//   from there and moves to the result register once that register is free.
//   One poll per cycle is sustained while out_stall is low; the rate is set by
//   the combinational path through the loop state: offset subtract, integral clamp, 33x17 multiply, time add.
// Stall:
//   While out_stall holds a result, the input register still takes one poll;
//   in_stall rises only when that register is full and cannot drain.
// Reset:
//   arst_n clears both registers' valid bits, sets the loop state to no second
//   seen with zero time, offset and integral, and loads default settings.
//
module clock_discipline_pi (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [cdpi_pkg::SEC_W-1:0]           rtc_second,
	input  logic [cdpi_pkg::EPOCH_W-1:0]         rtc_epoch_seconds,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [cdpi_pkg::TIME_W-1:0]          timestamp,
	output logic                                 stepped,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  cdpi_pkg::cfg_reg_t                   cfg_index,
	input  logic [cdpi_pkg::CFG_W-1:0]           cfg_data
);

	// configuration registers
	logic [cdpi_pkg::CFG_W-1:0]  step_interval_q;
	logic [cdpi_pkg::CFG_W-1:0]  step_limit_q;
	logic [cdpi_pkg::CFG_W-1:0]  integral_limit_q;
	logic [cdpi_pkg::GAIN_W-1:0] integral_gain_q;

	// input register
	logic                          valid_s1;
	logic [cdpi_pkg::SEC_W-1:0]    sec_s1;
	logic [cdpi_pkg::EPOCH_W-1:0]  epoch_s1;

	// loop state
	logic [cdpi_pkg::LAST_W-1:0]         last_second_q;
	logic [cdpi_pkg::TIME_W-1:0]         local_time_q;
	logic [cdpi_pkg::TIME_W-1:0]         offset_error_q;
	logic signed [cdpi_pkg::INTEG_W-1:0] integral_q;

	// result register
	logic                        out_valid_q;
	logic [cdpi_pkg::TIME_W-1:0] timestamp_q;
	logic                        stepped_q;

	logic                                advance;
	logic                                new_sec;
	logic [cdpi_pkg::TIME_W-1:0]         rtc_ts;
	logic signed [cdpi_pkg::TIME_W-1:0]  diff;
	logic signed [cdpi_pkg::TIME_W-1:0]  slim;
	logic                                do_step;
	logic [cdpi_pkg::TIME_W-1:0]         err;
	logic signed [cdpi_pkg::SUM_W-1:0]   sum;
	logic signed [cdpi_pkg::SUM_W-1:0]   ilim;
	logic signed [cdpi_pkg::INTEG_W-1:0] integ_next;
	logic signed [cdpi_pkg::PROD_W-1:0]  prod;
	logic [cdpi_pkg::TIME_W-1:0]         adj;
	logic [cdpi_pkg::TIME_W-1:0]         offset_next;
	logic [cdpi_pkg::TIME_W-1:0]         time_next;

	assign advance   = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall  = valid_s1 & ~advance;
	assign cfg_ready = 1'b1;

	assign out_valid = out_valid_q;
	assign timestamp = timestamp_q;
	assign stepped   = stepped_q;

	always_comb begin
		new_sec = {1'b0, sec_s1} != last_second_q;
		rtc_ts  = cdpi_pkg::TIME_W'(epoch_s1) << cdpi_pkg::TIME_FRAC_BITS;
		diff    = signed'(rtc_ts - local_time_q);
		slim    = signed'(cdpi_pkg::TIME_W'(step_limit_q));
		do_step = new_sec & ((diff > slim) | (diff < -slim));
		err     = new_sec ? diff : offset_error_q;

		// integral + offset, clamped to +/- integral_limit without overflow
		sum  = signed'({{2{err[cdpi_pkg::TIME_W-1]}}, err})
		     + cdpi_pkg::SUM_W'(integral_q);
		ilim = signed'(cdpi_pkg::SUM_W'(integral_limit_q));
		if (sum >= ilim)
			integ_next = signed'({1'b0, integral_limit_q});
		else if (sum <= -ilim)
			integ_next = -signed'({1'b0, integral_limit_q});
		else
			integ_next = sum[cdpi_pkg::INTEG_W-1:0];

		// arithmetic shift gives floor of integral * gain / 2^16
		prod = cdpi_pkg::PROD_W'(integ_next)
		     * cdpi_pkg::PROD_W'(signed'({1'b0, integral_gain_q}));
		adj  = cdpi_pkg::TIME_W'(signed'(prod[cdpi_pkg::PROD_W-1:cdpi_pkg::GAIN_FRAC_BITS]));

		offset_next = err - adj;
		time_next   = local_time_q + cdpi_pkg::TIME_W'(step_interval_q) + adj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_interval_q  <= cdpi_pkg::STEP_INTERVAL_RST;
			step_limit_q     <= cdpi_pkg::STEP_LIMIT_RST;
			integral_limit_q <= cdpi_pkg::INTEGRAL_LIMIT_RST;
			integral_gain_q  <= cdpi_pkg::INTEGRAL_GAIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cdpi_pkg::REG_STEP_INTERVAL:  step_interval_q  <= cfg_data;
				cdpi_pkg::REG_STEP_LIMIT:     step_limit_q     <= cfg_data;
				cdpi_pkg::REG_INTEGRAL_LIMIT: integral_limit_q <= cfg_data;
				cdpi_pkg::REG_INTEGRAL_GAIN:  integral_gain_q  <= cfg_data[cdpi_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sec_s1   <= rtc_second;
			epoch_s1 <= rtc_epoch_seconds;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_second_q  <= cdpi_pkg::NO_SECOND;
			local_time_q   <= '0;
			offset_error_q <= '0;
			integral_q     <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (advance) begin
				if (new_sec)
					last_second_q <= {1'b0, sec_s1};
				if (do_step) begin
					local_time_q   <= rtc_ts;
					offset_error_q <= '0;
					integral_q     <= '0;
				end else begin
					local_time_q   <= time_next;
					offset_error_q <= offset_next;
					integral_q     <= integ_next;
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			timestamp_q <= do_step ? rtc_ts : time_next;
			stepped_q   <= do_step;
		end
	end

endmodule

// ===== hdl/cdpi_checker.sv =====
// Port-level checker for the clock discipline loop, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cdpi_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [cdpi_pkg::TIME_W-1:0] timestamp,
	input logic                        stepped
);

	// a held result stays offered and unchanged
	`AST_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`AST_NEXT(a_out_stable, out_valid && out_stall, $stable(timestamp) && $stable(stepped))
	// with the result register empty, the input side never stalls
	`AST_NOW(a_no_stall_empty, !out_valid, !in_stall)
	// a step lands on a whole RTC second
	`AST_NOW(a_step_whole, out_valid && stepped,
		timestamp[cdpi_pkg::TIME_FRAC_BITS-1:0] == '0)

endmodule

bind clock_discipline_pi cdpi_checker u_cdpi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.timestamp (timestamp),
	.stepped   (stepped)
);

// ===== test/tb_clock_discipline_pi.sv =====
// Testbench for clock_discipline_pi: RTC polls checked against a behavioral loop model.
`timescale 1ns / 1ps

module tb_clock_discipline_pi;

	localparam int HOLD_CYCLES = 80;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_POLLS = 112;

	typedef struct {
		logic [cdpi_pkg::SEC_W-1:0]   sec;
		logic [cdpi_pkg::EPOCH_W-1:0] epoch;
		logic                         typed;
		logic [cdpi_pkg::TIME_W-1:0]  ts;
		logic                         st;
	} poll_row_t;

	typedef struct {
		logic [cdpi_pkg::TIME_W-1:0] ts;
		logic                        st;
	} poll_result_t;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic [cdpi_pkg::SEC_W-1:0]   rtc_second;
	logic [cdpi_pkg::EPOCH_W-1:0] rtc_epoch_seconds;
	logic                         out_valid;
	logic                         out_stall;
	logic [cdpi_pkg::TIME_W-1:0]  timestamp;
	logic                         stepped;
	logic                         cfg_valid;
	logic                         cfg_ready;
	cdpi_pkg::cfg_reg_t           cfg_index;
	logic [cdpi_pkg::CFG_W-1:0]   cfg_data;

	clock_discipline_pi dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.rtc_second        (rtc_second),
		.rtc_epoch_seconds (rtc_epoch_seconds),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.timestamp         (timestamp),
		.stepped           (stepped),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	// loop model state and settings
	logic [cdpi_pkg::LAST_W-1:0] ls_last_sec;
	logic [cdpi_pkg::TIME_W-1:0] ls_time;
	logic [cdpi_pkg::TIME_W-1:0] ls_offset;
	longint                      ls_integ;
	logic [cdpi_pkg::CFG_W-1:0]  cf_interval;
	logic [cdpi_pkg::CFG_W-1:0]  cf_step_limit;
	logic [cdpi_pkg::CFG_W-1:0]  cf_integ_limit;
	logic [cdpi_pkg::GAIN_W-1:0] cf_gain;

	poll_result_t                due_q[$];
	int                          miss_cnt;
	int                          quiet_cycles;
	logic                        cur_typed;
	logic [cdpi_pkg::TIME_W-1:0] cur_ts;
	logic                        cur_st;
	logic                        gap_on;
	logic                        stall_on;
	logic                        hold_req;
	logic [cdpi_pkg::TIME_W-1:0] rtc_now;

	// after reset the default settings hold; typed rows are read straight off the loop rules
	poll_row_t dir_rows [21] = '{
		'{6'd0,  32'd0,          1'b1, 64'h0000_0000_2000_0000, 1'b0},
		'{6'd59, 32'd100,        1'b1, 64'h0000_0064_0000_0000, 1'b1},
		'{6'd59, 32'd100,        1'b1, 64'h0000_0064_2000_0000, 1'b0},
		'{6'd63, 32'hFFFF_FFFF,  1'b1, 64'hFFFF_FFFF_0000_0000, 1'b1},
		// time wraps: offset is +1 s, so it steps back to zero
		'{6'd62, 32'd0,          1'b1, 64'h0000_0000_0000_0000, 1'b1},
		'{6'd62, 32'd0,          1'b1, 64'h0000_0000_2000_0000, 1'b0},
		// offset exactly -step_limit: no step, integral at the negative rail
		'{6'd2,  32'd0,          1'b0, 64'd0, 1'b0},
		'{6'd2,  32'd0,          1'b0, 64'd0, 1'b0},
		'{6'd3,  32'd0,          1'b0, 64'd0, 1'b0},
		'{6'd3,  32'd0,          1'b0, 64'd0, 1'b0},
		'{6'd3,  32'd0,          1'b0, 64'd0, 1'b0},
		'{6'd3,  32'd0,          1'b0, 64'd0, 1'b0},
		'{6'd3,  32'd0,          1'b0, 64'd0, 1'b0},
		'{6'd3,  32'd0,          1'b0, 64'd0, 1'b0},
		'{6'd3,  32'd0,          1'b0, 64'd0, 1'b0},
		'{6'd3,  32'd0,          1'b0, 64'd0, 1'b0},
		// local at 7/8 s, RTC at 1 s: offset +step_limit, positive rail
		'{6'd4,  32'd1,          1'b0, 64'd0, 1'b0},
		'{6'd4,  32'd1,          1'b0, 64'd0, 1'b0},
		'{6'd60, 32'd1,          1'b0, 64'd0, 1'b0},
		'{6'd61, 32'd1,          1'b0, 64'd0, 1'b0},
		'{6'd0,  32'hFFFF_FFFF,  1'b1, 64'hFFFF_FFFF_0000_0000, 1'b1}
	};

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// One poll through the integral loop; updates the model state.
	task automatic discipline_poll(input logic [cdpi_pkg::SEC_W-1:0] sec,
			input logic [cdpi_pkg::EPOCH_W-1:0] epoch,
			output logic [cdpi_pkg::TIME_W-1:0] ts, output logic st);
		logic [cdpi_pkg::TIME_W-1:0] rtc_ts;
		logic [cdpi_pkg::TIME_W-1:0] diff;
		logic [cdpi_pkg::TIME_W-1:0] mag;
		longint                      e;
		longint                      lim;
		longint                      adj;
		st = 1'b0;
		if ({1'b0, sec} != ls_last_sec) begin
			rtc_ts = {epoch, {cdpi_pkg::TIME_FRAC_BITS{1'b0}}};
			diff = rtc_ts - ls_time;
			mag = diff[cdpi_pkg::TIME_W-1] ? -diff : diff;
			ls_last_sec = {1'b0, sec};
			if (mag > {32'd0, cf_step_limit}) begin
				ls_time = rtc_ts;
				ls_offset = '0;
				ls_integ = 0;
				st = 1'b1;
			end else begin
				ls_offset = diff;
			end
		end
		if (!st) begin
			e = longint'(ls_offset);
			lim = longint'({32'd0, cf_integ_limit});
			if (e >= lim - ls_integ)
				ls_integ = lim;
			else if (e <= -lim - ls_integ)
				ls_integ = -lim;
			else
				ls_integ = ls_integ + e;
			// arithmetic shift gives the floor of the scaled product
			adj = (ls_integ * longint'({48'd0, cf_gain})) >>> cdpi_pkg::GAIN_FRAC_BITS;
			ls_offset = ls_offset - adj;
			ls_time = ls_time + {32'd0, cf_interval} + adj;
		end
		ts = ls_time;
	endtask

	task automatic flag_miss(input string what, input logic [cdpi_pkg::TIME_W-1:0] want_v,
			input logic [cdpi_pkg::TIME_W-1:0] got_v);
		miss_cnt++;
		if (miss_cnt <= 10)
			$display("mismatch on %s: expected %h, got %h", what, want_v, got_v);
	endtask

	// Offers one poll from a falling edge; returns at the falling edge after the transfer.
	task automatic send_poll(input logic [cdpi_pkg::SEC_W-1:0] sec,
			input logic [cdpi_pkg::EPOCH_W-1:0] epoch, input logic typed,
			input logic [cdpi_pkg::TIME_W-1:0] ts, input logic st);
		if (gap_on && !hold_req && $urandom_range(0, 5) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		in_valid = 1'b1;
		rtc_second = sec;
		rtc_epoch_seconds = epoch;
		cur_typed = typed;
		cur_ts = ts;
		cur_st = st;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic cfg_write(input cdpi_pkg::cfg_reg_t idx,
			input logic [cdpi_pkg::CFG_W-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic load_settings(input logic [cdpi_pkg::CFG_W-1:0] si,
			input logic [cdpi_pkg::CFG_W-1:0] sl, input logic [cdpi_pkg::CFG_W-1:0] il,
			input logic [cdpi_pkg::GAIN_W-1:0] gain);
		in_valid = 1'b0;
		while (due_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_write(cdpi_pkg::REG_STEP_INTERVAL, si);
		cfg_write(cdpi_pkg::REG_STEP_LIMIT, sl);
		cfg_write(cdpi_pkg::REG_INTEGRAL_LIMIT, il);
		cfg_write(cdpi_pkg::REG_INTEGRAL_GAIN, {16'd0, gain});
	endtask

	// Polls of a drifting RTC, with some garbage reads and clock jumps mixed in.
	task automatic random_polls(input int count, input logic idle_ok, input logic squeeze);
		int                           n;
		int                           r;
		logic [cdpi_pkg::SEC_W-1:0]   sec;
		logic [cdpi_pkg::EPOCH_W-1:0] epoch;
		for (n = 0; n < count; n++) begin
			if (n % 40 == 0) begin
				gap_on = idle_ok && ($urandom_range(0, 2) != 0);
				stall_on = idle_ok && ($urandom_range(0, 2) != 0);
			end
			if (squeeze && n == 30)
				hold_req = 1'b1;
			r = $urandom_range(0, 99);
			if (r < 3)
				rtc_now = {$urandom(), $urandom()};
			// ~1/8 s per poll with a few ms of jitter either way
			rtc_now = rtc_now + 64'd536870912 + 64'($urandom_range(0, 32'h0100_0000))
				- 64'd8388608;
			if (r >= 3 && r < 13) begin
				sec = cdpi_pkg::SEC_W'($urandom_range(0, 63));
				epoch = $urandom();
			end else begin
				epoch = rtc_now[cdpi_pkg::TIME_W-1:cdpi_pkg::TIME_FRAC_BITS];
				sec = cdpi_pkg::SEC_W'(epoch % 60);
			end
			send_poll(sec, epoch, 1'b0, '0, 1'b0);
		end
	endtask

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
				out_stall = 1'b0;
			end else if (stall_on && $urandom_range(0, 7) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(0, 16)) @(negedge clk);
				out_stall = 1'b0;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin : observe
		poll_result_t                want;
		logic [cdpi_pkg::TIME_W-1:0] ts;
		logic                        st;
		logic                        moved;
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
				case (cfg_index)
					cdpi_pkg::REG_STEP_INTERVAL:  cf_interval = cfg_data;
					cdpi_pkg::REG_STEP_LIMIT:     cf_step_limit = cfg_data;
					cdpi_pkg::REG_INTEGRAL_LIMIT: cf_integ_limit = cfg_data;
					cdpi_pkg::REG_INTEGRAL_GAIN:  cf_gain = cfg_data[cdpi_pkg::GAIN_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				discipline_poll(rtc_second, rtc_epoch_seconds, ts, st);
				if (cur_typed) begin
					ts = cur_ts;
					st = cur_st;
				end
				due_q.push_back('{ts, st});
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				if (due_q.size() == 0) begin
					flag_miss("result with nothing due", '0, timestamp);
				end else begin
					want = due_q.pop_front();
					if (want.ts !== timestamp)
						flag_miss("timestamp", want.ts, timestamp);
					if (want.st !== stepped)
						flag_miss("stepped", {63'd0, want.st}, {63'd0, stepped});
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		rtc_second = '0;
		rtc_epoch_seconds = '0;
		cfg_valid = 1'b0;
		cfg_index = cdpi_pkg::REG_STEP_INTERVAL;
		cfg_data = '0;
		cur_typed = 1'b0;
		cur_ts = '0;
		cur_st = 1'b0;
		gap_on = 1'b1;
		stall_on = 1'b1;
		hold_req = 1'b0;
		miss_cnt = 0;
		quiet_cycles = 0;
		rtc_now = {$urandom(), $urandom()};
		ls_last_sec = cdpi_pkg::NO_SECOND;
		ls_time = '0;
		ls_offset = '0;
		ls_integ = 0;
		cf_interval = cdpi_pkg::STEP_INTERVAL_RST;
		cf_step_limit = cdpi_pkg::STEP_LIMIT_RST;
		cf_integ_limit = cdpi_pkg::INTEGRAL_LIMIT_RST;
		cf_gain = cdpi_pkg::INTEGRAL_GAIN_RST;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_poll(dir_rows[i].sec, dir_rows[i].epoch, dir_rows[i].typed,
				dir_rows[i].ts, dir_rows[i].st);
		random_polls(PHASE_POLLS, 1'b1, 1'b0);

		// no correction, widest limits: integral runs up to its rail
		load_settings(32'h2000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0);
		random_polls(PHASE_POLLS, 1'b1, 1'b1);
		// rail lowered under a full integral, full gain
		load_settings(32'h2000_0000, 32'hFFFF_FFFF, 32'd12345, 16'hFFFF);
		random_polls(PHASE_POLLS, 1'b1, 1'b0);
		load_settings(32'd0, 32'd0, 32'd0, 16'd328);
		random_polls(PHASE_POLLS, 1'b1, 1'b0);
		load_settings(32'hFFFF_FFFF, 32'h8000_0000, 32'h4000_0000,
			16'($urandom_range(1, 65535)));
		random_polls(PHASE_POLLS, 1'b1, 1'b1);
		load_settings($urandom(), $urandom(), $urandom(), 16'($urandom()));
		random_polls(PHASE_POLLS, 1'b1, 1'b0);
		// closing stretch runs back to back on both sides
		load_settings(32'h1000_0000, 32'h2000_0000, 32'h2000_0000, 16'd328);
		random_polls(PHASE_POLLS, 1'b0, 1'b0);

		in_valid = 1'b0;
		while (due_q.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (miss_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
